/* rtl/lenia_generation_step_top_defines.svh */
// assertion macros shared by the lenia generation step rtl
// depends on nothing; included by files that carry assertions
`ifndef LENIA_GENERATION_STEP_TOP_DEFINES_SVH
`define LENIA_GENERATION_STEP_TOP_DEFINES_SVH

// same-cycle implication under reset
`define LGS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define LGS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lgs_pkg.sv */
// shared types and constants for the lenia generation step block
// no dependencies
package lgs_pkg;
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int MAX_KPTS   = 1024;
  localparam int CELL_MAX   = 255;

  localparam int COORD_W = 7;
  localparam int CELL_W  = 8;
  localparam int ADDR_W  = 14;
  localparam int KIDX_W  = 10;
  localparam int KCNT_W  = 11;
  localparam int OFS_W   = 6;
  localparam int KW_W    = 10;
  localparam int DIM_W   = 8;
  localparam int WT_W    = 20;
  localparam int SUM_W   = 28;
  localparam int POP_W   = 22;
  localparam int GEN_W   = 32;
  localparam int REQ_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 3'd0,
    REQ_READ  = 3'd1,
    REQ_KERN  = 3'd2,
    REQ_GROW  = 3'd3,
    REQ_RUN   = 3'd4
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH   = 2'd0,
    CFG_GRID_HEIGHT  = 2'd1,
    CFG_KERNEL_COUNT = 2'd2,
    CFG_WEIGHT_TOTAL = 2'd3
  } cfg_idx_t;
endpackage

/* rtl/lgs_if.sv */
// valid/ready channel interfaces for items and results
// depends on lgs_pkg
interface lgs_in_if;
  logic valid;
  logic ready;
  logic [lgs_pkg::REQ_W-1:0]   req_type;
  logic [lgs_pkg::COORD_W-1:0] cell_x;
  logic [lgs_pkg::COORD_W-1:0] cell_y;
  logic [lgs_pkg::CELL_W-1:0]  cell_value;
  logic [lgs_pkg::KIDX_W-1:0]  table_index;
  logic signed [lgs_pkg::OFS_W-1:0] offset_dx;
  logic signed [lgs_pkg::OFS_W-1:0] offset_dy;
  logic [lgs_pkg::KW_W-1:0]    kernel_weight;
  logic signed [lgs_pkg::CELL_W-1:0] growth_delta;

  modport source (output valid, req_type, cell_x, cell_y, cell_value, table_index,
                  offset_dx, offset_dy, kernel_weight, growth_delta, input ready);
  modport sink (input valid, req_type, cell_x, cell_y, cell_value, table_index,
                offset_dx, offset_dy, kernel_weight, growth_delta, output ready);
endinterface

interface lgs_out_if;
  logic valid;
  logic ready;
  logic [lgs_pkg::CELL_W-1:0] read_value;
  logic [lgs_pkg::POP_W-1:0]  population;
  logic [lgs_pkg::GEN_W-1:0]  generation;

  modport source (output valid, read_value, population, generation, input ready);
  modport sink (input valid, read_value, population, generation, output ready);
endinterface

/* rtl/lgs_div.sv */
// capped quotient unit: min(dividend / divisor, 255), zero divisor gives zero
// restoring division, one quotient bit per cycle; depends on lgs_pkg
module lgs_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lgs_pkg::SUM_W-1:0]  dividend,
  input  logic [lgs_pkg::WT_W-1:0]   divisor,
  output logic                       done,
  output logic [lgs_pkg::CELL_W-1:0] quot
);
  import lgs_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  dvs_r, dvs_nxt;
  logic [CELL_W-1:0] q_r, q_nxt;
  logic [SUM_W-1:0]  trial;

  assign trial = dvs_r << cnt_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    if (start) begin
      dvs_nxt = {{(SUM_W-WT_W){1'b0}}, divisor};
      rem_nxt = dividend;
      cnt_nxt = 3'd7;
      q_nxt   = '0;
      if (divisor == '0) begin
        done_nxt = 1'b1;
      end else if (dividend >= {divisor, 8'b0}) begin
        q_nxt    = CELL_W'(CELL_MAX);
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        q_nxt   = q_r | (CELL_W'(1) << cnt_r);
      end
      cnt_nxt = cnt_r - 3'd1;
      if (cnt_r == 3'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

/* rtl/lenia_generation_step_top.sv */
// lenia generation step: item decode, cell planes, kernel and growth tables, run sequencer
// items: write/load pass exec then result; read passes exec, a plane read wait, then result
// run: 128*128 cells; inactive ones pass cell, centre read and write-back; active ones add divide,
//   growth read and update, plus per kernel point a read, load, wrap steps and MAC; single plane read port
// one item at a time; in ready only when the sequencer is idle
// reset (synchronous, rst_n low) resets control registers and grid defaults, then the clear state zeroes both planes
module lenia_generation_step_top (
  input  logic                           clk,
  input  logic                           rst_n,
  lgs_in_if.sink                         in_ch,
  lgs_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lgs_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import lgs_pkg::*;
  `include "lenia_generation_step_top_defines.svh"

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_EXEC, S_RDW, S_CELL, S_CTR, S_KRD, S_KLD,
    S_WRAP, S_MAC, S_DST, S_DIV, S_GRD, S_UPD, S_WB, S_RES
  } state_t;

  state_t state_r;

  // configuration
  logic [DIM_W-1:0]  gw_r, gh_r;
  logic [KCNT_W-1:0] kc_r;
  logic [WT_W-1:0]   wt_r;
  logic [DIM_W-1:0]  aw, ah;
  logic [KCNT_W-1:0] n_eff;

  // latched item
  req_t              req_r;
  logic [COORD_W-1:0] cx_r, cy_r;
  logic [CELL_W-1:0] cval_r;
  logic [KIDX_W-1:0] tidx_r;
  logic [OFS_W-1:0]  dx_r, dy_r;
  logic [KW_W-1:0]   kwin_r;
  logic [CELL_W-1:0] gd_r;

  // run datapath
  logic [ADDR_W-1:0]  clr_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic [KCNT_W-1:0]  k_r;
  logic [SUM_W-1:0]   sum_r;
  logic [CELL_W-1:0]  center_r, val_r;
  logic [KW_W-1:0]    kw_r;
  logic signed [8:0]  nx_r, ny_r;
  logic               act_r;
  logic [POP_W-1:0]   pop_r;
  logic               sel_r;
  logic [GEN_W-1:0]   gen_r;
  logic [CELL_W-1:0]  res_rv_r;
  logic [POP_W-1:0]   res_pop_r;

  logic               out_valid_r;
  logic [CELL_W-1:0]  out_rv_r;
  logic [POP_W-1:0]   out_pop_r;
  logic [GEN_W-1:0]   out_gen_r;

  // memories
  logic [CELL_W-1:0] plane_a [MAX_WIDTH*MAX_HEIGHT];
  logic [CELL_W-1:0] plane_b [MAX_WIDTH*MAX_HEIGHT];
  logic [21:0]       kern_mem [MAX_KPTS];
  logic [CELL_W-1:0] grow_mem [256];
  logic [CELL_W-1:0] pa_rd_r, pb_rd_r, gr_rd_r;
  logic [21:0]       kern_rd_r;

  logic [ADDR_W-1:0] pl_rd_addr, pl_wa;
  logic              pl_we_a, pl_we_b;
  logic [CELL_W-1:0] pl_wd, cur_rd;
  logic              div_start, div_done;
  logic [CELL_W-1:0] div_q;

  logic               in_grid;
  logic               x_in, y_in;
  logic signed [8:0]  aw9, ah9;
  logic [OFS_W-1:0]   dx_c, dy_c;
  logic signed [9:0]  upd_sum;
  logic               last_cell;

  assign aw = (gw_r == '0) ? DIM_W'(1) : ((gw_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : gw_r);
  assign ah = (gh_r == '0) ? DIM_W'(1)
                           : ((gh_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : gh_r);
  assign n_eff = (kc_r > KCNT_W'(MAX_KPTS)) ? KCNT_W'(MAX_KPTS) : kc_r;
  assign aw9 = $signed({1'b0, aw});
  assign ah9 = $signed({1'b0, ah});
  assign cur_rd = sel_r ? pb_rd_r : pa_rd_r;
  assign in_grid = ({1'b0, cx_r} < aw) && ({1'b0, cy_r} < ah);
  assign x_in = (nx_r >= 0) && (nx_r < aw9);
  assign y_in = (ny_r >= 0) && (ny_r < ah9);
  // the one code below -31 clamps to -31
  assign dx_c = (dx_r == 6'b100000) ? 6'b100001 : dx_r;
  assign dy_c = (dy_r == 6'b100000) ? 6'b100001 : dy_r;
  assign upd_sum = $signed({2'b00, center_r}) + $signed({{2{gr_rd_r[7]}}, gr_rd_r});
  assign last_cell = (x_r == '1) && (y_r == '1);

  lgs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (wt_r),
    .done     (div_done),
    .quot     (div_q)
  );

  // memory port control
  always_comb begin
    pl_rd_addr = {y_r, x_r};
    pl_wa      = {y_r, x_r};
    pl_wd      = val_r;
    pl_we_a    = 1'b0;
    pl_we_b    = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        pl_wa   = clr_r;
        pl_wd   = '0;
        pl_we_a = 1'b1;
        pl_we_b = 1'b1;
      end
      S_EXEC: begin
        pl_rd_addr = {cy_r, cx_r};
        pl_wa      = {cy_r, cx_r};
        pl_wd      = cval_r;
        if (req_r == REQ_WRITE && in_grid) begin
          pl_we_a = !sel_r;
          pl_we_b = sel_r;
        end
      end
      S_WRAP: pl_rd_addr = {ny_r[COORD_W-1:0], nx_r[COORD_W-1:0]};
      S_DST:  div_start = 1'b1;
      S_WB: begin
        pl_we_a = sel_r;
        pl_we_b = !sel_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pl_we_a) plane_a[pl_wa] <= pl_wd;
    if (pl_we_b) plane_b[pl_wa] <= pl_wd;
    pa_rd_r <= plane_a[pl_rd_addr];
    pb_rd_r <= plane_b[pl_rd_addr];
    if (state_r == S_EXEC && req_r == REQ_KERN) kern_mem[tidx_r] <= {dx_c, dy_c, kwin_r};
    kern_rd_r <= kern_mem[k_r[KIDX_W-1:0]];
    if (state_r == S_EXEC && req_r == REQ_GROW && tidx_r[KIDX_W-1:8] == '0) begin
      grow_mem[tidx_r[7:0]] <= gd_r;
    end
    gr_rd_r <= grow_mem[div_q];
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      gw_r        <= DIM_W'(92);
      gh_r        <= DIM_W'(112);
      kc_r        <= '0;
      wt_r        <= '0;
      sel_r       <= 1'b0;
      gen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_GRID_WIDTH:   gw_r <= cfg_wdata[DIM_W-1:0];
          CFG_GRID_HEIGHT:  gh_r <= cfg_wdata[DIM_W-1:0];
          CFG_KERNEL_COUNT: kc_r <= cfg_wdata[KCNT_W-1:0];
          CFG_WEIGHT_TOTAL: wt_r <= cfg_wdata[WT_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_RES && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + ADDR_W'(1);
          if (clr_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            req_r   <= req_t'(in_ch.req_type);
            cx_r    <= in_ch.cell_x;
            cy_r    <= in_ch.cell_y;
            cval_r  <= in_ch.cell_value;
            tidx_r  <= in_ch.table_index;
            dx_r    <= in_ch.offset_dx;
            dy_r    <= in_ch.offset_dy;
            kwin_r  <= in_ch.kernel_weight;
            gd_r    <= in_ch.growth_delta;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_rv_r  <= '0;
          res_pop_r <= '0;
          x_r       <= '0;
          y_r       <= '0;
          pop_r     <= '0;
          if (req_r == REQ_READ) begin
            state_r <= S_RDW;
          end else if (req_r == REQ_RUN) begin
            state_r <= S_CELL;
          end else begin
            state_r <= S_RES;
          end
        end
        S_RDW: begin
          res_rv_r <= in_grid ? cur_rd : '0;
          state_r  <= S_RES;
        end
        S_CELL: state_r <= S_CTR;
        S_CTR: begin
          center_r <= cur_rd;
          val_r    <= cur_rd;
          sum_r    <= '0;
          k_r      <= '0;
          act_r    <= ({1'b0, x_r} < aw) && ({1'b0, y_r} < ah);
          if (({1'b0, x_r} < aw) && ({1'b0, y_r} < ah)) begin
            state_r <= (n_eff == '0) ? S_DST : S_KRD;
          end else begin
            state_r <= S_WB;
          end
        end
        S_KRD: state_r <= S_KLD;
        S_KLD: begin
          nx_r    <= $signed({2'b00, x_r}) + $signed({{3{kern_rd_r[21]}}, kern_rd_r[21:16]});
          ny_r    <= $signed({2'b00, y_r}) + $signed({{3{kern_rd_r[15]}}, kern_rd_r[15:10]});
          kw_r    <= kern_rd_r[KW_W-1:0];
          state_r <= S_WRAP;
        end
        S_WRAP: begin
          // one modulo step per axis per cycle
          if (x_in && y_in) begin
            state_r <= S_MAC;
          end else begin
            if (nx_r < 0) nx_r <= nx_r + aw9;
            else if (!x_in) nx_r <= nx_r - aw9;
            if (ny_r < 0) ny_r <= ny_r + ah9;
            else if (!y_in) ny_r <= ny_r - ah9;
          end
        end
        S_MAC: begin
          sum_r   <= sum_r + SUM_W'(18'(cur_rd) * 18'(kw_r));
          k_r     <= k_r + KCNT_W'(1);
          state_r <= (k_r + KCNT_W'(1) == n_eff) ? S_DST : S_KRD;
        end
        S_DST: state_r <= S_DIV;
        S_DIV: if (div_done) state_r <= S_GRD;
        S_GRD: state_r <= S_UPD;
        S_UPD: begin
          priority if (upd_sum < 0) val_r <= '0;
          else if (upd_sum > 10'sd255) val_r <= CELL_W'(CELL_MAX);
          else val_r <= upd_sum[CELL_W-1:0];
          state_r <= S_WB;
        end
        S_WB: begin
          if (act_r) pop_r <= pop_r + POP_W'(val_r);
          x_r <= x_r + COORD_W'(1);
          if (x_r == '1) y_r <= y_r + COORD_W'(1);
          if (last_cell) begin
            res_pop_r <= act_r ? pop_r + POP_W'(val_r) : pop_r;
            sel_r     <= !sel_r;
            gen_r     <= gen_r + GEN_W'(1);
            state_r   <= S_RES;
          end else begin
            state_r <= S_CELL;
          end
        end
        S_RES: begin
          if (!out_valid_r || out_ch.ready) begin
            out_rv_r    <= res_rv_r;
            out_pop_r   <= res_pop_r;
            out_gen_r   <= gen_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_rv_r;
  assign out_ch.population = out_pop_r;
  assign out_ch.generation = out_gen_r;

  `LGS_ASSERT_IMP(a_clr_blocks, state_r == S_CLR, !in_ch.ready, "item taken during clear")
  `LGS_ASSERT_NXT(a_gen_swap, state_r == S_WB && last_cell, sel_r != $past(sel_r),
                  "plane swap missing at run end")
  `LGS_ASSERT_IMP(a_mac_bound, state_r == S_MAC, k_r < n_eff, "kernel index past count")
  `LGS_ASSERT_IMP(a_div_zero, div_done && wt_r == '0, div_q == '0,
                  "zero weight total gives nonzero average")
endmodule
